// File: hdl/ccf_pkg.sv
package ccf_pkg;

  localparam int TIME_W = 41;
  localparam int MS_W = 29;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int POS_W = 5;

  localparam logic [MS_W-1:0] TIME_MAX_MS = 29'd359999999;

  localparam logic MODE_TIMING = 1'b0;
  localparam logic MODE_TEXT = 1'b1;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // positions within the timing line
  localparam logic [POS_W-1:0] POS_END_RELOAD = 5'd16;
  localparam logic [POS_W-1:0] POS_END_TIME = 5'd17;
  localparam logic [POS_W-1:0] POS_END_TIME_LAST = 5'd28;
  localparam logic [POS_W-1:0] POS_LINE_END = 5'd29;
  localparam logic [POS_W-1:0] POS_CUE_END = 5'd31;
  localparam logic [POS_W-1:0] POS_TIME_LEN = 5'd12;

  typedef enum logic [1:0] {
    BODY_NONE = 2'd0,
    BODY_BYTE = 2'd1,
    BODY_ENT  = 2'd2
  } body_t;

  typedef struct packed {
    logic            is_timing;
    logic [MS_W-1:0] from_ms;
    logic [MS_W-1:0] end_ms;
    logic            empty;
    logic [1:0]      lead;
    body_t           body;
    logic [7:0]      text;
    logic [1:0]      trail;
    logic            fin;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [1:0] held;
  } front_stat_t;

  typedef struct packed {
    logic idle;
  } back_stat_t;

  typedef struct packed {
    logic       is_digit;
    logic [3:0] idx;
    logic [7:0] ch;
  } pos_info_t;

  typedef logic [9:0][MS_W-1:0] thr_row_t;

  // one HH:MM:SS.mmm field, q = 0..11
  function automatic pos_info_t time_char(input logic [3:0] q);
    pos_info_t r;
    r.is_digit = 1'b1;
    r.idx = 4'd0;
    r.ch = CH_SPACE;
    case (q)
      4'd0: r.idx = 4'd0;
      4'd1: r.idx = 4'd1;
      4'd2: begin
        r.is_digit = 1'b0;
        r.ch = CH_COLON;
      end
      4'd3: r.idx = 4'd2;
      4'd4: r.idx = 4'd3;
      4'd5: begin
        r.is_digit = 1'b0;
        r.ch = CH_COLON;
      end
      4'd6: r.idx = 4'd4;
      4'd7: r.idx = 4'd5;
      4'd8: begin
        r.is_digit = 1'b0;
        r.ch = CH_DOT;
      end
      4'd9: r.idx = 4'd6;
      4'd10: r.idx = 4'd7;
      4'd11: r.idx = 4'd8;
      default: r.is_digit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic pos_info_t line_char(input logic [POS_W-1:0] pos);
    pos_info_t r;
    r.is_digit = 1'b0;
    r.idx = 4'd0;
    r.ch = CH_SPACE;
    if (pos < POS_TIME_LEN) begin
      r = time_char(pos[3:0]);
    end else if (pos >= POS_END_TIME && pos <= POS_END_TIME_LAST) begin
      r = time_char(4'(pos - POS_END_TIME));
    end else begin
      case (pos)
        5'd13, 5'd14: r.ch = CH_DASH;
        5'd15: r.ch = CH_GT;
        5'd29, 5'd30, 5'd31: r.ch = CH_NL;
        default: r.ch = CH_SPACE;
      endcase
    end
    return r;
  endfunction

  // multiples 0..9 of the place value of digit idx
  function automatic thr_row_t digit_thr(input logic [3:0] idx);
    thr_row_t r;
    for (int k = 0; k < 10; k++) begin
      case (idx)
        4'd0: r[k] = MS_W'(k * 36000000);
        4'd1: r[k] = MS_W'(k * 3600000);
        4'd2: r[k] = MS_W'(k * 600000);
        4'd3: r[k] = MS_W'(k * 60000);
        4'd4: r[k] = MS_W'(k * 10000);
        4'd5: r[k] = MS_W'(k * 1000);
        4'd6: r[k] = MS_W'(k * 100);
        4'd7: r[k] = MS_W'(k * 10);
        4'd8: r[k] = MS_W'(k);
        default: r[k] = '0;
      endcase
    end
    return r;
  endfunction

endpackage

// File: hdl/ccf_front.sv
module ccf_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic                               mode,
  input  logic signed [ccf_pkg::TIME_W-1:0]  start_time_ms,
  input  logic signed [ccf_pkg::TIME_W-1:0]  end_time_ms,
  input  logic                               empty_text,
  input  logic [7:0]                         text_byte,
  input  logic                               final_text_byte,
  output ccf_pkg::push_t                     push,
  output ccf_pkg::front_stat_t               stat
);

  logic [1:0] held;
  logic [1:0] held_next;
  ccf_pkg::cmd_t cmd;
  logic is_dash;
  logic is_gt;

  function automatic logic [ccf_pkg::MS_W-1:0] clamp_ms(
    input logic [ccf_pkg::TIME_W-1:0] t
  );
    logic [ccf_pkg::MS_W-1:0] r;
    if (t[ccf_pkg::TIME_W-1]) begin
      r = '0;
    end else if (t > ccf_pkg::TIME_W'(ccf_pkg::TIME_MAX_MS)) begin
      r = ccf_pkg::TIME_MAX_MS;
    end else begin
      r = t[ccf_pkg::MS_W-1:0];
    end
    return r;
  endfunction

  assign is_dash = (text_byte == ccf_pkg::CH_DASH);
  assign is_gt = (text_byte == ccf_pkg::CH_GT);

  always_comb begin
    held_next = held;
    cmd.is_timing = 1'b0;
    cmd.from_ms = clamp_ms(start_time_ms);
    cmd.end_ms = clamp_ms(end_time_ms);
    cmd.empty = empty_text;
    cmd.lead = 2'd0;
    cmd.body = ccf_pkg::BODY_NONE;
    cmd.text = text_byte;
    cmd.trail = 2'd0;
    cmd.fin = 1'b0;
    if (mode == ccf_pkg::MODE_TIMING) begin
      cmd.is_timing = 1'b1;
      held_next = 2'd0;
    end else begin
      if (is_dash && held != 2'd2) begin
        held_next = held + 2'd1;
      end else if (is_dash) begin
        cmd.body = ccf_pkg::BODY_BYTE;
      end else if (is_gt && held == 2'd2) begin
        cmd.lead = 2'd2;
        cmd.body = ccf_pkg::BODY_ENT;
        held_next = 2'd0;
      end else begin
        cmd.lead = held;
        cmd.body = ccf_pkg::BODY_BYTE;
        held_next = 2'd0;
      end
      if (final_text_byte) begin
        cmd.fin = 1'b1;
        cmd.trail = held_next;
        held_next = 2'd0;
      end
    end
  end

  assign push.cmd = cmd;
  assign push.valid = accept && (cmd.is_timing || cmd.fin || cmd.body != ccf_pkg::BODY_NONE);
  assign stat.held = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
    end else if (accept) begin
      held <= held_next;
    end
  end

endmodule

// File: hdl/ccf_fifo.sv
module ccf_fifo (
  input  logic               clk,
  input  logic               rst,
  input  ccf_pkg::push_t     push,
  input  logic               pop,
  output ccf_pkg::cmd_t      head,
  output ccf_pkg::q_stat_t   stat
);

  ccf_pkg::cmd_t entries [ccf_pkg::QDEPTH];
  logic [ccf_pkg::QPTR_W-1:0] wr_ptr;
  logic [ccf_pkg::QPTR_W-1:0] rd_ptr;
  logic [ccf_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign stat.full = (count == ccf_pkg::QCNT_W'(ccf_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push = push.valid && !stat.full;
  assign do_pop = pop && !stat.empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ccf_back.sv
module ccf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ccf_pkg::cmd_t         head,
  input  ccf_pkg::q_stat_t      qstat,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  output logic                  end_of_item,
  output logic                  end_of_cue,
  output ccf_pkg::back_stat_t   stat
);

  typedef enum logic [5:0] {
    PH_DONE  = 6'b000001,
    PH_TIME  = 6'b000010,
    PH_LEAD  = 6'b000100,
    PH_BODY  = 6'b001000,
    PH_TRAIL = 6'b010000,
    PH_NL    = 6'b100000
  } phase_t;

  phase_t phase, phase_next, ph_after;
  logic [ccf_pkg::POS_W-1:0] pos, pos_next;
  logic [ccf_pkg::MS_W-1:0] rem, rem_next;
  logic [ccf_pkg::MS_W-1:0] end_ms, end_ms_next;
  logic empty, empty_next;
  logic [1:0] lead, lead_next;
  ccf_pkg::body_t body, body_next;
  logic [7:0] text, text_next;
  logic [1:0] ent_cnt, ent_cnt_next;
  logic [1:0] trail, trail_next;
  logic fin, fin_next;
  logic nl_cnt, nl_cnt_next;

  logic emit;
  logic last;
  logic [7:0] byte_c;
  logic eoc_c;
  ccf_pkg::pos_info_t info;
  ccf_pkg::thr_row_t thr;
  logic [3:0] dcnt;

  function automatic phase_t text_phase(
    input logic [1:0] l,
    input ccf_pkg::body_t b,
    input logic [1:0] t,
    input logic f
  );
    phase_t p;
    if (l != 2'd0) begin
      p = PH_LEAD;
    end else if (b != ccf_pkg::BODY_NONE) begin
      p = PH_BODY;
    end else if (t != 2'd0) begin
      p = PH_TRAIL;
    end else if (f) begin
      p = PH_NL;
    end else begin
      p = PH_DONE;
    end
    return p;
  endfunction

  function automatic logic [7:0] ent_char(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0: c = ccf_pkg::CH_AMP;
      2'd1: c = ccf_pkg::CH_G;
      2'd2: c = ccf_pkg::CH_T;
      default: c = ccf_pkg::CH_SEMI;
    endcase
    return c;
  endfunction

  assign emit = (phase != PH_DONE) && (!out_valid || !out_stall);
  assign info = ccf_pkg::line_char(pos);
  assign thr = ccf_pkg::digit_thr(info.idx);
  assign stat.idle = (phase == PH_DONE);

  // digit of the remaining value at the current place
  always_comb begin
    dcnt = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= thr[k]) begin
        dcnt = 4'(k);
      end
    end
  end

  always_comb begin
    ph_after = phase;
    pos_next = pos;
    rem_next = rem;
    end_ms_next = end_ms;
    empty_next = empty;
    lead_next = lead;
    body_next = body;
    text_next = text;
    ent_cnt_next = ent_cnt;
    trail_next = trail;
    fin_next = fin;
    nl_cnt_next = nl_cnt;
    byte_c = ccf_pkg::CH_SPACE;
    eoc_c = 1'b0;

    case (phase)
      PH_TIME: begin
        if (info.is_digit) begin
          byte_c = ccf_pkg::CH_0 + {4'd0, dcnt};
          rem_next = rem - thr[dcnt];
        end else begin
          byte_c = info.ch;
        end
        if (pos == ccf_pkg::POS_END_RELOAD) begin
          rem_next = end_ms;
        end
        eoc_c = (pos == ccf_pkg::POS_CUE_END);
        if (pos == ccf_pkg::POS_CUE_END || (pos == ccf_pkg::POS_LINE_END && !empty)) begin
          ph_after = PH_DONE;
        end else begin
          pos_next = pos + 1'b1;
        end
      end
      PH_LEAD: begin
        byte_c = ccf_pkg::CH_DASH;
        lead_next = lead - 2'd1;
        ph_after = text_phase(lead_next, body, trail, fin);
      end
      PH_BODY: begin
        if (body == ccf_pkg::BODY_ENT && ent_cnt != 2'd3) begin
          byte_c = ent_char(ent_cnt);
          ent_cnt_next = ent_cnt + 2'd1;
        end else begin
          byte_c = (body == ccf_pkg::BODY_ENT) ? ent_char(ent_cnt) : text;
          body_next = ccf_pkg::BODY_NONE;
          ph_after = text_phase(2'd0, ccf_pkg::BODY_NONE, trail, fin);
        end
      end
      PH_TRAIL: begin
        byte_c = ccf_pkg::CH_DASH;
        trail_next = trail - 2'd1;
        ph_after = text_phase(2'd0, ccf_pkg::BODY_NONE, trail_next, fin);
      end
      PH_NL: begin
        byte_c = ccf_pkg::CH_NL;
        if (!nl_cnt) begin
          nl_cnt_next = 1'b1;
        end else begin
          eoc_c = 1'b1;
          ph_after = PH_DONE;
        end
      end
      default: ph_after = PH_DONE;
    endcase

    last = (ph_after == PH_DONE);
    pop = !qstat.empty && (phase == PH_DONE || (emit && last));
    phase_next = emit ? ph_after : phase;

    if (pop) begin
      pos_next = '0;
      rem_next = head.from_ms;
      end_ms_next = head.end_ms;
      empty_next = head.empty;
      lead_next = head.lead;
      body_next = head.body;
      text_next = head.text;
      ent_cnt_next = 2'd0;
      trail_next = head.trail;
      fin_next = head.fin;
      nl_cnt_next = 1'b0;
      phase_next = head.is_timing ? PH_TIME :
                   text_phase(head.lead, head.body, head.trail, head.fin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DONE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer state only moves when a byte goes out or a command is loaded
  always_ff @(posedge clk) begin
    if (emit || pop) begin
      pos <= pos_next;
      rem <= rem_next;
      end_ms <= end_ms_next;
      empty <= empty_next;
      lead <= lead_next;
      body <= body_next;
      text <= text_next;
      ent_cnt <= ent_cnt_next;
      trail <= trail_next;
      fin <= fin_next;
      nl_cnt <= nl_cnt_next;
    end
    if (emit) begin
      out_byte <= byte_c;
      end_of_item <= last;
      end_of_cue <= eoc_c;
    end
  end

endmodule

// File: hdl/caption_cue_formatter_top.sv
// an item is queued, then loaded into the sequencer that registers its bytes
// throughput: one byte per cycle from the byte sequencer while not stalled; a
//   text item giving at most one byte is taken every cycle, a timing item
//   gives 30 bytes (32 with the empty-cue newlines) on the one-byte output port
// a 4-entry command queue lets input transfers continue while a line drains
// reset: synchronous, active high; clears held dashes, queue and output valid
module caption_cue_formatter_top (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic signed [ccf_pkg::TIME_W-1:0]  start_time_ms,
  input  logic signed [ccf_pkg::TIME_W-1:0]  end_time_ms,
  input  logic                               empty_text,
  input  logic [7:0]                         text_byte,
  input  logic                               final_text_byte,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_byte,
  output logic                               end_of_item,
  output logic                               end_of_cue
);

  // front: classifies each item and tracks held dashes
  // queue: decouples classification from byte sequencing
  // back: expands one command into bytes, converting times digit by digit
  ccf_pkg::push_t push;
  ccf_pkg::q_stat_t qstat;
  ccf_pkg::cmd_t head;
  ccf_pkg::front_stat_t fstat;
  ccf_pkg::back_stat_t bstat;
  logic pop;
  logic accept;

  // stall straight from the queue level so it never waits on the back end
  assign in_stall = qstat.full;
  assign accept = in_valid && !in_stall;

  ccf_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .mode            (mode),
    .start_time_ms   (start_time_ms),
    .end_time_ms     (end_time_ms),
    .empty_text      (empty_text),
    .text_byte       (text_byte),
    .final_text_byte (final_text_byte),
    .push            (push),
    .stat            (fstat)
  );

  ccf_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (qstat)
  );

  // back end pops the next command on the same cycle it sends a last byte
  ccf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .end_of_item (end_of_item),
    .end_of_cue  (end_of_cue),
    .stat        (bstat)
  );

  // a cue always closes on a newline that also ends its item
  a_cue_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_cue |-> end_of_item && out_byte == ccf_pkg::CH_NL)
    else $error("cue end not on a closing newline");

  // never more than two dashes held back
  a_held: assert property (@(posedge clk) disable iff (rst)
    fstat.held != 2'd3)
    else $error("held dash count out of range");

  // an idle sequencer picks up a waiting command right away
  a_pickup: assert property (@(posedge clk) disable iff (rst)
    bstat.idle && !qstat.empty |=> !bstat.idle)
    else $error("queued command not picked up");

  // a full queue means the sequencer is busy
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !bstat.idle)
    else $error("queue full while sequencer idle");

endmodule

// File: sim/tb_caption_cue_formatter_top.sv
module tb_caption_cue_formatter_top;
  timeunit 1ns;
  timeprecision 1ps;

  // run limits
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  // extremes of the 41-bit signed time fields
  localparam logic signed [ccf_pkg::TIME_W-1:0] TIME_MIN =
    {1'b1, {(ccf_pkg::TIME_W-1){1'b0}}};
  localparam logic signed [ccf_pkg::TIME_W-1:0] TIME_TOP =
    {1'b0, {(ccf_pkg::TIME_W-1){1'b1}}};

  // one formatted output byte as the checker expects it
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    logic       eoc;
  } cue_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              mode = ccf_pkg::MODE_TIMING;
  logic signed [ccf_pkg::TIME_W-1:0] start_time_ms = '0;
  logic signed [ccf_pkg::TIME_W-1:0] end_time_ms = '0;
  logic                              empty_text = 1'b0;
  logic [7:0]                        text_byte = 8'h00;
  logic                              final_text_byte = 1'b0;

  // output channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       end_of_item;
  logic       end_of_cue;

  // predictor state: dashes held back waiting for a possible '>'
  logic [1:0] dash_hold = 2'd0;

  // bytes predicted but not yet seen on the output, oldest first
  cue_byte_t pending_cue_bytes[$];

  int mismatch_count = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int cycle_count = 0;

  // idle mix, in percent per cycle
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  // long receiver hold: the stimulus bumps the request, the stall process
  // acknowledges it and counts the hold down on its own
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  caption_cue_formatter_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .start_time_ms   (start_time_ms),
    .end_time_ms     (end_time_ms),
    .empty_text      (empty_text),
    .text_byte       (text_byte),
    .final_text_byte (final_text_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .end_of_item     (end_of_item),
    .end_of_cue      (end_of_cue)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
               pending_cue_bytes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // HH:MM:SS.mmm with negative times clamped to zero and large ones saturated
  function automatic string cue_time(input logic signed [ccf_pkg::TIME_W-1:0] t);
    longint ms;
    ms = longint'(t);
    if (ms < 0) begin
      ms = 0;
    end else if (ms > longint'(ccf_pkg::TIME_MAX_MS)) begin
      ms = longint'(ccf_pkg::TIME_MAX_MS);
    end
    return $sformatf("%02d:%02d:%02d.%03d", ms / 3600000, (ms / 60000) % 60,
                     (ms / 1000) % 60, ms % 1000);
  endfunction

  // works out the bytes one accepted transfer causes and queues them
  function automatic void format_cue_item(input logic m,
                                          input logic signed [ccf_pkg::TIME_W-1:0] st,
                                          input logic signed [ccf_pkg::TIME_W-1:0] en,
                                          input logic emp,
                                          input logic [7:0] b,
                                          input logic fin);
    logic [7:0] chars[$];
    string      line;
    logic       closes;
    cue_byte_t  nb;
    closes = 1'b0;
    if (m == ccf_pkg::MODE_TIMING) begin
      // dashes left from an unclosed cue are simply dropped
      dash_hold = 2'd0;
      line = {cue_time(st), " --> ", cue_time(en), "\n"};
      if (emp) begin
        line = {line, "\n\n"};
        closes = 1'b1;
      end
      for (int i = 0; i < line.len(); i++) begin
        chars.insert(chars.size(), line[i]);
      end
    end else begin
      if (b == ccf_pkg::CH_DASH) begin
        // a third dash pushes the oldest one out, two stay held
        if (dash_hold < 2'd2) begin
          dash_hold++;
        end else begin
          chars.insert(chars.size(), ccf_pkg::CH_DASH);
        end
      end else if (b == ccf_pkg::CH_GT && dash_hold == 2'd2) begin
        dash_hold = 2'd0;
        chars.insert(chars.size(), ccf_pkg::CH_DASH);
        chars.insert(chars.size(), ccf_pkg::CH_DASH);
        chars.insert(chars.size(), ccf_pkg::CH_AMP);
        chars.insert(chars.size(), ccf_pkg::CH_G);
        chars.insert(chars.size(), ccf_pkg::CH_T);
        chars.insert(chars.size(), ccf_pkg::CH_SEMI);
      end else begin
        repeat (dash_hold) chars.insert(chars.size(), ccf_pkg::CH_DASH);
        dash_hold = 2'd0;
        chars.insert(chars.size(), b);
      end
      if (fin) begin
        repeat (dash_hold) chars.insert(chars.size(), ccf_pkg::CH_DASH);
        dash_hold = 2'd0;
        chars.insert(chars.size(), ccf_pkg::CH_NL);
        chars.insert(chars.size(), ccf_pkg::CH_NL);
        closes = 1'b1;
      end
    end
    foreach (chars[i]) begin
      nb.ch = chars[i];
      nb.eoi = (i == chars.size() - 1);
      nb.eoc = closes && (i == chars.size() - 1);
      pending_cue_bytes.insert(pending_cue_bytes.size(), nb);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // output side: stall generation and checking
  // ---------------------------------------------------------------------------

  // random stall, or the long hold when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // sampled at the falling edge, where everything for the next rising edge
  // has settled; a transfer happens there when valid is up and stall is down
  always @(negedge clk) begin : check_cue_bytes
    cue_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      bytes_checked++;
      if (pending_cue_bytes.size() == 0) begin
        $error("unexpected output byte %h (end_of_item %b, end_of_cue %b)",
               out_byte, end_of_item, end_of_cue);
        mismatch_count++;
      end else begin
        want = pending_cue_bytes.pop_front();
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %h, actual %h", want.ch, out_byte);
          mismatch_count++;
        end
        if (end_of_item !== want.eoi) begin
          $error("end_of_item: expected %b, actual %b", want.eoi, end_of_item);
          mismatch_count++;
        end
        if (end_of_cue !== want.eoc) begin
          $error("end_of_cue: expected %b, actual %b", want.eoc, end_of_cue);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one transfer on the input channel; called right after a rising edge and
  // returns right after the edge that took the item
  task automatic send_item(input logic m, input logic signed [ccf_pkg::TIME_W-1:0] st,
                           input logic signed [ccf_pkg::TIME_W-1:0] en, input logic emp,
                           input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    start_time_ms <= st;
    end_time_ms <= en;
    empty_text <= emp;
    text_byte <= b;
    final_text_byte <= fin;
    // stall is final by the falling edge; the item goes at the next rising one
    @(negedge clk);
    while (in_stall) begin
      @(negedge clk);
    end
    format_cue_item(m, st, en, emp, b, fin);
    items_sent++;
    @(posedge clk);
  endtask

  // timing item, text fields filled with noise
  task automatic send_timing(input logic signed [ccf_pkg::TIME_W-1:0] st,
                             input logic signed [ccf_pkg::TIME_W-1:0] en,
                             input logic emp);
    send_item(ccf_pkg::MODE_TIMING, st, en, emp, 8'($urandom()), 1'($urandom()));
  endtask

  // text byte, time fields and empty flag filled with noise
  task automatic send_text(input logic [7:0] b, input logic fin);
    send_item(ccf_pkg::MODE_TEXT, ccf_pkg::TIME_W'({$urandom(), $urandom()}),
              ccf_pkg::TIME_W'({$urandom(), $urandom()}), 1'($urandom()), b, fin);
  endtask

  // sender goes idle until every predicted byte has been checked
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_cue_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // half in range, with negative, near-saturation, huge and fully random values
  function automatic logic signed [ccf_pkg::TIME_W-1:0] rand_cue_time();
    logic signed [ccf_pkg::TIME_W-1:0] t;
    case ($urandom_range(0, 7))
      0: t = ccf_pkg::TIME_W'({$urandom(), $urandom()});
      1: t = -ccf_pkg::TIME_W'($urandom_range(1, 5000));
      2: t = ccf_pkg::TIME_W'(ccf_pkg::TIME_MAX_MS) - ccf_pkg::TIME_W'(1000)
             + ccf_pkg::TIME_W'($urandom_range(0, 2000));
      3: t = TIME_TOP - ccf_pkg::TIME_W'($urandom());
      default: t = ccf_pkg::TIME_W'($urandom_range(0, 359999999));
    endcase
    return t;
  endfunction

  // text bytes weighted toward the escape sequence
  function automatic logic [7:0] rand_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return ccf_pkg::CH_DASH;
    end else if (r < 65) begin
      return ccf_pkg::CH_GT;
    end
    return 8'($urandom());
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // clamp at zero, saturation at 99:59:59.999, field extremes, empty cues
  task automatic test_time_extremes();
    send_timing(41'sd0, 41'sd359999999, 1'b1);
    send_timing(-41'sd1, 41'sd360000000, 1'b1);
    send_timing(TIME_MIN, TIME_TOP, 1'b0);
    send_text(8'h00, 1'b1);
    send_timing(41'sd359999998, 41'sd3723004, 1'b0);
    send_text(8'hFF, 1'b1);
  endtask

  // arrow escape, runs of dashes, lone '>' and dashes flushed by the last byte
  task automatic test_dash_escape();
    send_timing(41'sd1000, 41'sd2000, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_GT, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_GT, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_GT, 1'b0);
    send_text("a", 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b1);
  endtask

  // held dashes are dropped when a new cue starts
  task automatic test_dropped_dashes();
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_text(ccf_pkg::CH_DASH, 1'b0);
    send_timing(41'sd5000, 41'sd6000, 1'b1);
  endtask

  // sender goes quiet until every predicted byte has come out
  task automatic test_sender_pause();
    send_timing(41'sd61000, 41'sd3599999, 1'b0);
    send_text("x", 1'b1);
    wait_for_drain();
    @(posedge clk);
    send_timing(41'sd7, 41'sd86399999, 1'b1);
  endtask

  // random cues under one idle mix; mostly well-formed, some noise items
  task automatic test_random_cues(input int tx_pct, input int rx_pct, input int n);
    int target;
    int len;
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) == 0) begin
          send_timing(rand_cue_time(), rand_cue_time(), 1'b1);
        end else begin
          send_timing(rand_cue_time(), rand_cue_time(), 1'b0);
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            send_text(rand_text_byte(), i == len - 1);
          end
        end
      end else begin
        // broken sequences: any mode, any flags
        send_item(1'($urandom()), rand_cue_time(), rand_cue_time(), 1'($urandom()),
                  rand_text_byte(), 1'($urandom()));
      end
    end
  endtask

  // receiver holds off while the sender keeps offering; the block fills up
  // and has to stall its input
  task automatic test_receiver_hold();
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 10; i++) begin
      send_timing(rand_cue_time(), rand_cue_time(), i % 3 == 0);
      send_text(rand_text_byte(), 1'b0);
    end
    send_text("z", 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_time_extremes();
    test_dash_escape();
    test_dropped_dashes();
    test_sender_pause();
    test_random_cues(0, 0, 32);
    test_random_cues(65, 0, 32);
    test_random_cues(0, 65, 32);
    test_random_cues(26, 26, 32);
    test_receiver_hold();
    rx_stall_pct <= 0;

    // let everything drain, then give stray bytes a chance to show up
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d input transfers and %0d output bytes: time clamping,",
             items_sent, bytes_checked);
    $display("arrow escaping, dropped dashes, four idle mixes, a long hold and a drain pause");
    if (mismatch_count == 0 && pending_cue_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
